// File: hdl/vc_pkg.sv
`timescale 1ns / 1ps

package vc_pkg;

    localparam int unsigned GroupBits = 7;
    localparam int unsigned MaxBytes  = 10;
    localparam int unsigned CntBits   = 4;
    localparam int unsigned ValueBits = 64;
    localparam int unsigned ByteBits  = 8;

    localparam logic [CntBits-1:0] LastCnt = CntBits'(MaxBytes - 1);

    // Input selector carried in the slave-side tuser.
    typedef enum logic {
        t_CMD_ENCODE = 1'b0,
        t_CMD_DECODE = 1'b1
    } t_cmd;

    // Byte stream leaving the encoder.
    typedef struct packed {
        logic                valid;
        logic [ByteBits-1:0] data;
        logic                last;
    } t_enc_out;

    // Value leaving the decoder in the cycle its final byte is taken.
    typedef struct packed {
        logic                 done;
        logic [ValueBits-1:0] value;
    } t_dec_out;

endpackage

// File: hdl/varint_codec.sv
`timescale 1ns / 1ps

// Variable-length integer codec, 7-bit groups, low group first, bit 7 set
// when more bytes follow. A beat with tuser = 0 encodes tdata[63:0] into one
// to ten output beats, one per cycle while the output is not stalled, the
// final one with tlast high; the input stays stalled until the encoder has
// handed its last byte to the output register. A beat with tuser = 1 feeds
// tdata[71:64] to the decoder; a byte without the continuation bit, or the
// tenth byte of a run, completes the value, which then appears as one beat
// with tlast high and the byte field zero. Encode beats in the middle of a
// decode run leave the run untouched. The encoder is a 64-bit shift register
// that drops one 7-bit digit per cycle while the output accepts it; the
// decoder collects digits in ten lanes. With signed_mode set, the sign
// travels in bit 0, below the magnitude. The configuration register is
// written through its own channel, which is always ready; the user must
// write it only while no item is in flight: the block itself does not enforce this.
module varint_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // signed_mode

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,    // value_in [63:0], byte_in [71:64]
    input  logic        s_axis_tuser,    // cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,    // byte_out [7:0], value_out [71:8]
    output logic        m_axis_tlast     // last
);

    logic              r_signed;
    logic              r_ovalid;
    logic              n_ovalid;
    logic [71:0]       r_odata;
    logic [71:0]       n_odata;
    logic              r_olast;
    logic              n_olast;
    logic              w_slot_free;
    logic              w_in_acc;
    logic              w_enc_load;
    logic              w_dec_push;
    logic              w_enc_adv;
    vc_pkg::t_cmd      w_cmd;
    vc_pkg::t_enc_out  w_enc;
    vc_pkg::t_dec_out  w_dec;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed <= 1'b0;
        end else if (i_cfg_valid) begin
            r_signed <= i_cfg_data;
        end
    end

    // The output register is free when empty or being drained this cycle.
    assign w_slot_free   = !r_ovalid || m_axis_tready;
    assign s_axis_tready = !w_enc.valid && w_slot_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = vc_pkg::t_cmd'(s_axis_tuser);
    assign w_enc_load    = w_in_acc && (w_cmd == vc_pkg::t_CMD_ENCODE);
    assign w_dec_push    = w_in_acc && (w_cmd == vc_pkg::t_CMD_DECODE);
    assign w_enc_adv     = w_enc.valid && w_slot_free;

    vc_enc u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_signed(r_signed),
        .i_load  (w_enc_load),
        .i_value (s_axis_tdata[63:0]),
        .i_adv   (w_enc_adv),
        .o_enc   (w_enc)
    );

    vc_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_signed(r_signed),
        .i_push  (w_dec_push),
        .i_byte  (s_axis_tdata[71:64]),
        .o_res   (w_dec)
    );

    // Encoder bytes and decoder values never compete: the input is held off
    // for as long as the encoder has bytes left.
    always_comb begin
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        n_olast  = r_olast;
        if (w_enc_adv) begin
            n_ovalid = 1'b1;
            n_odata  = {64'd0, w_enc.data};
            n_olast  = w_enc.last;
        end else if (w_dec.done) begin
            n_ovalid = 1'b1;
            n_odata  = {w_dec.value, 8'd0};
            n_olast  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_enc_adv && w_dec.done))
        else $error("encoder and decoder both load the output register");
    a_decode_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dec.done |=> (r_ovalid && r_olast && r_odata[7:0] == 8'd0))
        else $error("decoded value not presented as a last beat");
`endif

endmodule

// File: hdl/vc_enc.sv
`timescale 1ns / 1ps

module vc_enc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_signed,
    input  logic                          i_load,
    input  logic [vc_pkg::ValueBits-1:0]  i_value,
    input  logic                          i_adv,
    output vc_pkg::t_enc_out              o_enc
);

    logic                         r_busy;
    logic                         n_busy;
    logic [vc_pkg::ValueBits-1:0] r_sh;
    logic [vc_pkg::ValueBits-1:0] n_sh;
    logic [vc_pkg::ValueBits-1:0] w_neg;
    logic [vc_pkg::ValueBits-1:0] w_zig;
    logic                         w_last;

    // Sign goes to bit 0, the magnitude sits above it.
    always_comb begin
        w_neg = '0 - i_value;
        if (i_value[vc_pkg::ValueBits-1]) begin
            w_zig = {w_neg[vc_pkg::ValueBits-2:0], 1'b1};
        end else begin
            w_zig = {i_value[vc_pkg::ValueBits-2:0], 1'b0};
        end
    end

    assign w_last = (r_sh[vc_pkg::ValueBits-1:vc_pkg::GroupBits] == '0);

    always_comb begin
        n_busy = r_busy;
        n_sh   = r_sh;
        if (i_load) begin
            n_busy = 1'b1;
            n_sh   = i_signed ? w_zig : i_value;
        end else if (i_adv) begin
            n_sh = r_sh >> vc_pkg::GroupBits;
            if (w_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_sh <= n_sh;
    end

    assign o_enc.valid = r_busy;
    assign o_enc.data  = {~w_last, r_sh[vc_pkg::GroupBits-1:0]};
    assign o_enc.last  = w_last;

`ifndef SYNTHESIS
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_adv && w_last) |=> !r_busy)
        else $error("encoder still busy after its last byte");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_busy)
        else $error("encoder loaded while a run is in flight");
`endif

endmodule

// File: hdl/vc_dec.sv
`timescale 1ns / 1ps

module vc_dec (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_signed,
    input  logic                         i_push,
    input  logic [vc_pkg::ByteBits-1:0]  i_byte,
    output vc_pkg::t_dec_out             o_res
);

    localparam int unsigned AllBits = vc_pkg::MaxBytes * vc_pkg::GroupBits;

    logic [vc_pkg::GroupBits-1:0] r_grp [vc_pkg::MaxBytes];
    logic [vc_pkg::CntBits-1:0]   r_cnt;
    logic [AllBits-1:0]           w_all;
    logic [vc_pkg::ValueBits-1:0] w_acc;
    logic [vc_pkg::ValueBits-1:0] w_mag;
    logic                         w_final;

    assign w_final = !i_byte[vc_pkg::ByteBits-1] || (r_cnt == vc_pkg::LastCnt);

    // Each lane holds one group; the incoming group stands in at the count.
    always_comb begin
        for (int k = 0; k < vc_pkg::MaxBytes; k++) begin
            if (r_cnt == vc_pkg::CntBits'(k)) begin
                w_all[k*vc_pkg::GroupBits +: vc_pkg::GroupBits] =
                    i_byte[vc_pkg::GroupBits-1:0];
            end else begin
                w_all[k*vc_pkg::GroupBits +: vc_pkg::GroupBits] = r_grp[k];
            end
        end
    end

    assign w_acc = w_all[vc_pkg::ValueBits-1:0];
    assign w_mag = {1'b0, w_acc[vc_pkg::ValueBits-1:1]};

    always_comb begin
        o_res.done = i_push && w_final;
        if (!i_signed) begin
            o_res.value = w_acc;
        end else if (w_acc[0]) begin
            o_res.value = '0 - w_mag;
        end else begin
            o_res.value = w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int k = 0; k < vc_pkg::MaxBytes; k++) begin
                r_grp[k] <= '0;
            end
        end else if (i_push) begin
            if (w_final) begin
                r_cnt <= '0;
                for (int k = 0; k < vc_pkg::MaxBytes; k++) begin
                    r_grp[k] <= '0;
                end
            end else begin
                r_cnt <= r_cnt + 1'b1;
                for (int k = 0; k < vc_pkg::MaxBytes; k++) begin
                    if (r_cnt == vc_pkg::CntBits'(k)) begin
                        r_grp[k] <= i_byte[vc_pkg::GroupBits-1:0];
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= vc_pkg::LastCnt)
        else $error("decode count beyond the tenth byte");
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && w_final) |=> (r_cnt == '0))
        else $error("decode count not cleared after a value");
`endif

endmodule
